[hdl/assert_macros.svh]
// Assertion helpers shared by the allocator RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is high.
`define PSA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define PSA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/psa_pkg.sv]
// Types and constants for the proportional share allocator.
// No dependencies; used by every RTL file of the block.
`timescale 1ns / 1ps
`default_nettype none

package psa_pkg;

   localparam int ENTRY_W     = 31;
   localparam int IDX_W       = 5;
   localparam int MAX_ENTRIES = 32;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int WGT_W       = ENTRY_W + 1;
   localparam int TOT_W       = WGT_W + ADDR_W;
   localparam int PROD_W      = ENTRY_W + WGT_W;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [ENTRY_W-1:0] FULL_AMOUNT = {ENTRY_W{1'b1}};

   typedef struct packed {
      logic [ENTRY_W-1:0] budget;
      logic [ENTRY_W-1:0] used_amount;
      logic [ENTRY_W-1:0] wanted_amount;
      logic               last_entry;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]   entry_index;
      logic [ENTRY_W-1:0] granted_amount;
      logic               last_result;
   } rsp_type;

   // Classified entry handed from front to back
   typedef struct packed {
      logic [ENTRY_W-1:0] budget;
      logic [ENTRY_W-1:0] used_amount;
      logic [ENTRY_W-1:0] wanted_amount;
      logic               last_entry;
      logic               first_entry;
      logic               keep_entry;
   } entry_type;

endpackage

`default_nettype wire

[hdl/psa_front.sv]
// Front end: accepts request beats, tags first/kept entries, queues them.
// Depends on psa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psa_front (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  psa_pkg::req_type      req_payload,
   output logic                  q_valid,
   output psa_pkg::entry_type    q_entry,
   input  wire                   q_pop
);

   localparam int PTR_W = $clog2(psa_pkg::QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(psa_pkg::QUEUE_DEPTH + 1);
   localparam int CNT_W = psa_pkg::CNT_W;

   psa_pkg::entry_type queue_ff [psa_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]          wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]         fill_ff, fill_in;
   logic [psa_pkg::CNT_W-1:0] seen_ff, seen_in;
   logic                      push, pop;
   psa_pkg::entry_type        tagged_entry;

   assign req_stall = (fill_ff == QCNT_W'(psa_pkg::QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (fill_ff != '0);
   assign q_entry   = queue_ff[rd_ptr_ff];
   assign pop       = q_pop && q_valid;

   // Classify the incoming beat against the set position
   always_comb begin
      tagged_entry.budget        = req_payload.budget;
      tagged_entry.used_amount   = req_payload.used_amount;
      tagged_entry.wanted_amount = req_payload.wanted_amount;
      tagged_entry.last_entry    = req_payload.last_entry;
      tagged_entry.first_entry   = (seen_ff == '0);
      tagged_entry.keep_entry    = (seen_ff < CNT_W'(psa_pkg::MAX_ENTRIES));
   end

   // Pointers, fill level and set position
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      seen_in   = seen_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(psa_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         if (req_payload.last_entry) begin
            seen_in = '0;
         end else if (tagged_entry.keep_entry) begin
            seen_in = seen_ff + 1'b1;
         end
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(psa_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
         seen_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
         seen_ff   <= seen_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= tagged_entry;
      end
   end

endmodule

`default_nettype wire

[hdl/psa_div.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on psa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psa_div (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         start,
   input  wire  [psa_pkg::PROD_W-1:0]  dividend,
   input  wire  [psa_pkg::TOT_W-1:0]   divisor,
   output logic                        done,
   output logic [psa_pkg::PROD_W-1:0]  quotient
);

   localparam int PW     = psa_pkg::PROD_W;
   localparam int TW     = psa_pkg::TOT_W;
   localparam int STEP_W = $clog2(PW + 1);

   logic [PW-1:0]     dvd_ff, dvd_in;
   logic [TW:0]       rem_ff, rem_in;
   logic [TW-1:0]     den_ff, den_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in, done_ff, done_in;
   logic [TW:0]       trial;
   logic              fits;

   assign trial    = {rem_ff[TW-1:0], dvd_ff[PW-1]};
   assign fits     = (trial >= {1'b0, den_ff});
   assign done     = done_ff;
   assign quotient = dvd_ff;

   // Shift-subtract step
   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         step_in = STEP_W'(PW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? (trial - {1'b0, den_ff}) : trial;
         dvd_in  = {dvd_ff[PW-2:0], fits};
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

endmodule

`default_nettype wire

[hdl/psa_back.sv]
// Back end: stores entries, runs the share rounds, emits grant beats.
// Depends on psa_pkg, psa_div and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module psa_back (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   q_valid,
   input  psa_pkg::entry_type    q_entry,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output psa_pkg::rsp_type      rsp_payload
);

   localparam int EW = psa_pkg::ENTRY_W;
   localparam int CW = psa_pkg::CNT_W;
   localparam int AW = psa_pkg::ADDR_W;
   localparam int WW = psa_pkg::WGT_W;
   localparam int TW = psa_pkg::TOT_W;
   localparam int PW = psa_pkg::PROD_W;

   localparam logic [3:0] S_LOAD  = 4'd0;
   localparam logic [3:0] S_INIT  = 4'd1;
   localparam logic [3:0] S_SUM   = 4'd2;
   localparam logic [3:0] S_MUL1  = 4'd3;
   localparam logic [3:0] S_CMP   = 4'd4;
   localparam logic [3:0] S_SHARE = 4'd5;
   localparam logic [3:0] S_MUL2  = 4'd6;
   localparam logic [3:0] S_DIVGO = 4'd7;
   localparam logic [3:0] S_DIV   = 4'd8;
   localparam logic [3:0] S_APPLY = 4'd9;
   localparam logic [3:0] S_EMIT  = 4'd10;

   logic [EW-1:0] usage_mem  [psa_pkg::MAX_ENTRIES];
   logic [EW-1:0] demand_mem [psa_pkg::MAX_ENTRIES];
   logic [EW-1:0] grant_mem  [psa_pkg::MAX_ENTRIES];

   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in, k_ff, k_in;
   logic [EW-1:0] budget_ff, budget_in, remaining_ff, remaining_in, tw_ff, tw_in;
   logic [EW-1:0] num_ff, num_in;
   logic [TW-1:0] total_ff, total_in, den_ff, den_in;
   logic [WW-1:0] top_ff, top_in;
   logic [PW-1:0] prod_ff, prod_in;
   logic          rsp_valid_ff, rsp_valid_in;
   psa_pkg::rsp_type rsp_ff, rsp_in;

   logic [AW-1:0] k_addr, load_addr;
   logic [EW-1:0] usage_k, demand_k, grant_k, need_k, share, grant_wr;
   logic [WW-1:0] weight_k;
   logic [WW:0]   tw_sum;
   logic          unsat_k, grant_we, out_free, div_go, div_done, at_end;
   logic [PW-1:0] quotient, share_wide;

   assign k_addr    = k_ff[AW-1:0];
   assign load_addr = cnt_ff[AW-1:0];
   assign usage_k   = usage_mem[k_addr];
   assign demand_k  = demand_mem[k_addr];
   assign grant_k   = grant_mem[k_addr];
   assign weight_k  = {1'b0, usage_k} + WW'(1);
   assign unsat_k   = (grant_k < demand_k);
   assign need_k    = demand_k - grant_k;
   assign tw_sum    = {2'b00, tw_ff} + {2'b00, demand_k};
   assign at_end    = (k_ff == cnt_ff);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign div_go    = (state_ff == S_DIVGO);
   assign q_pop     = (state_ff == S_LOAD);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Clip the quotient to the outstanding need and the remainder
   always_comb begin
      share_wide = (quotient > PW'(need_k)) ? PW'(need_k) : quotient;
      if (share_wide > PW'(remaining_ff)) begin
         share_wide = PW'(remaining_ff);
      end
      share = share_wide[EW-1:0];
   end

   psa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go),
      .dividend (prod_ff),
      .divisor  (den_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      k_in         = k_ff;
      budget_in    = budget_ff;
      remaining_in = remaining_ff;
      tw_in        = tw_ff;
      num_in       = num_ff;
      total_in     = total_ff;
      den_in       = den_ff;
      top_in       = top_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      grant_we     = 1'b0;
      grant_wr     = grant_k;
      case (state_ff)
         S_LOAD: begin
            if (q_valid) begin
               if (q_entry.first_entry) begin
                  budget_in = q_entry.budget;
               end
               if (q_entry.keep_entry) begin
                  cnt_in = cnt_ff + 1'b1;
               end
               if (q_entry.last_entry) begin
                  state_in = S_INIT;
                  k_in     = '0;
                  tw_in    = '0;
               end
            end
         end
         S_INIT: begin
            if (at_end) begin
               k_in     = '0;
               total_in = '0;
               top_in   = '0;
               if (budget_ff == psa_pkg::FULL_AMOUNT) begin
                  remaining_in = '0;
                  state_in     = S_EMIT;
               end else begin
                  remaining_in = (budget_ff < tw_ff) ? budget_ff : tw_ff;
                  state_in     = S_SUM;
               end
            end else begin
               grant_we = 1'b1;
               grant_wr = (budget_ff == psa_pkg::FULL_AMOUNT) ? demand_k : '0;
               tw_in    = tw_sum[WW-1] ? psa_pkg::FULL_AMOUNT : tw_sum[EW-1:0];
               k_in     = k_ff + 1'b1;
            end
         end
         S_SUM: begin
            if (remaining_ff == '0) begin
               k_in     = '0;
               state_in = S_EMIT;
            end else if (at_end) begin
               k_in     = '0;
               state_in = (total_ff == '0) ? S_EMIT : S_MUL1;
            end else begin
               if (unsat_k) begin
                  total_in = total_ff + TW'(weight_k);
                  if (weight_k > top_ff) begin
                     top_in = weight_k;
                  end
               end
               k_in = k_ff + 1'b1;
            end
         end
         S_MUL1: begin
            prod_in  = PW'(remaining_ff) * PW'(top_ff);
            state_in = S_CMP;
         end
         S_CMP: begin
            if (prod_ff <= PW'(total_ff)) begin
               num_in = EW'(1);
               den_in = TW'(top_ff);
            end else begin
               num_in = remaining_ff;
               den_in = total_ff;
            end
            k_in     = '0;
            state_in = S_SHARE;
         end
         S_SHARE: begin
            if (at_end || remaining_ff == '0) begin
               k_in     = '0;
               total_in = '0;
               top_in   = '0;
               state_in = S_SUM;
            end else if (unsat_k) begin
               state_in = S_MUL2;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         S_MUL2: begin
            prod_in  = PW'(weight_k) * PW'(num_ff);
            state_in = S_DIVGO;
         end
         S_DIVGO: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            grant_we     = 1'b1;
            grant_wr     = grant_k + share;
            remaining_in = remaining_ff - share;
            k_in         = k_ff + 1'b1;
            state_in     = S_SHARE;
         end
         S_EMIT: begin
            if (out_free) begin
               if (at_end) begin
                  cnt_in   = '0;
                  state_in = S_LOAD;
               end else begin
                  rsp_valid_in          = 1'b1;
                  rsp_in.entry_index    = k_ff[psa_pkg::IDX_W-1:0];
                  rsp_in.granted_amount = grant_k;
                  rsp_in.last_result    = (k_ff + 1'b1 == cnt_ff);
                  k_in                  = k_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         cnt_ff       <= '0;
         budget_ff    <= '0;
         remaining_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         budget_ff    <= budget_in;
         remaining_ff <= remaining_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      k_ff     <= k_in;
      tw_ff    <= tw_in;
      num_ff   <= num_in;
      total_ff <= total_in;
      den_ff   <= den_in;
      top_ff   <= top_in;
      prod_ff  <= prod_in;
      rsp_ff   <= rsp_in;
   end

   // Entry stores
   always_ff @(posedge clock) begin
      if (state_ff == S_LOAD && q_valid && q_entry.keep_entry) begin
         usage_mem[load_addr]  <= q_entry.used_amount;
         demand_mem[load_addr] <= q_entry.wanted_amount;
      end
      if (grant_we) begin
         grant_mem[k_addr] <= grant_wr;
      end
   end

   // Checks
   `PSA_ASSERT(a_grant_bound, clock, reset,
      (state_ff == S_APPLY) |-> (grant_wr <= demand_k), "grant above demand")
   `PSA_ASSERT(a_remaining_falls, clock, reset,
      (state_ff == S_APPLY) |=> (remaining_ff <= $past(remaining_ff)), "remaining grew")
   `PSA_ASSERT(a_done_in_div, clock, reset,
      div_done |-> (state_ff == S_DIV), "divider finished outside wait")

endmodule

`default_nettype wire

[hdl/proportional_share_allocator_top.sv]
// The beats of a set are loaded from the queue; a setup pass initialises the grants and
// sums the demand; share rounds follow, each served entry using the serial divider; then
// grant beats issue one per cycle while rsp_stall is low, and loading resumes. One set at
// a time: the next set loads once the last grant beat of the current set is issued. Reset
// (synchronous, active high) empties the queue and returns to loading; the entry stores
// hold no reset value. Top level: wires the front queue to the back end (psa_pkg).
`timescale 1ns / 1ps
`default_nettype none

module proportional_share_allocator_top (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  psa_pkg::req_type   req_payload,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output psa_pkg::rsp_type   rsp_payload
);

   logic               q_valid, q_pop;
   psa_pkg::entry_type q_entry;

   psa_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_valid     (q_valid),
      .q_entry     (q_entry),
      .q_pop       (q_pop)
   );

   psa_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_entry     (q_entry),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

[tb/sv/tb_proportional_share_allocator_top.sv]
// Testbench for the proportional share allocator: it sends requester sets, predicts every
// grant beat with its own allocation model, and checks each result beat in order.
// Depends on psa_pkg and proportional_share_allocator_top.
`timescale 1ns / 1ps

module tb_proportional_share_allocator_top;

   localparam int EW  = psa_pkg::ENTRY_W;
   localparam int MAXN = psa_pkg::MAX_ENTRIES;
   localparam logic [EW-1:0] UNLIMITED = psa_pkg::FULL_AMOUNT;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   psa_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   psa_pkg::rsp_type rsp_payload;

   proportional_share_allocator_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Allocation model state
   logic [EW-1:0] model_usage  [MAXN];
   logic [EW-1:0] model_demand [MAXN];
   int unsigned   model_count = 0;
   logic [EW-1:0] model_budget = '0;

   psa_pkg::rsp_type grant_queue[$];
   int      error_count = 0;
   bit      idle_on = 1'b1;

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Share out the held budget and queue one expected grant per stored entry
   task automatic compute_grants();
      longint unsigned grant [MAXN];
      longint unsigned rem, total, top, w, num, den, share, need, demand_sum;
      psa_pkg::rsp_type r;
      if (model_budget == UNLIMITED) begin
         for (int k = 0; k < model_count; k++) grant[k] = model_demand[k];
      end else begin
         demand_sum = 0;
         for (int k = 0; k < model_count; k++) begin
            grant[k] = 0;
            demand_sum += model_demand[k];
            if (demand_sum > UNLIMITED) demand_sum = UNLIMITED;
         end
         rem = (model_budget < demand_sum) ? model_budget : demand_sum;
         while (rem > 0) begin
            total = 0;
            top = 0;
            for (int k = 0; k < model_count; k++) begin
               if (grant[k] < model_demand[k]) begin
                  w = longint'(model_usage[k]) + 1;
                  if (w > top) top = w;
                  total += w;
               end
            end
            if (total == 0) break;
            num = rem;
            den = total;
            // tiny remainder: fall back to a scale of one over the largest weight
            if (num * top <= den) begin
               num = 1;
               den = top;
            end
            for (int k = 0; k < model_count && rem > 0; k++) begin
               if (grant[k] < model_demand[k]) begin
                  share = (longint'(model_usage[k]) + 1) * num / den;
                  need = model_demand[k] - grant[k];
                  if (share > need) share = need;
                  if (share > rem) share = rem;
                  grant[k] += share;
                  rem -= share;
               end
            end
         end
      end
      for (int k = 0; k < model_count; k++) begin
         r.entry_index    = k[psa_pkg::IDX_W-1:0];
         r.granted_amount = grant[k][EW-1:0];
         r.last_result    = (k + 1 == model_count);
         grant_queue.push_back(r);
      end
      model_count = 0;
   endtask

   task automatic absorb_entry(input psa_pkg::req_type e);
      if (model_count == 0) model_budget = e.budget;
      if (model_count < MAXN) begin
         model_usage[model_count]  = e.used_amount;
         model_demand[model_count] = e.wanted_amount;
         model_count++;
      end
      if (e.last_entry) compute_grants();
   endtask

   // Send one beat; called right after a rising edge
   task automatic send_entry(input psa_pkg::req_type e);
      int gap;
      gap = idle_on ? $urandom_range(0, 18) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= e;
      do @(posedge clock); while (req_stall);
      absorb_entry(e);
   endtask

   task automatic send_set(input logic [EW-1:0] budget,
                           input logic [EW-1:0] used[$],
                           input logic [EW-1:0] wanted[$]);
      psa_pkg::req_type e;
      for (int k = 0; k < used.size(); k++) begin
         e.budget        = (k == 0) ? budget : EW'($urandom());
         e.used_amount   = used[k];
         e.wanted_amount = wanted[k];
         e.last_entry    = (k + 1 == used.size());
         send_entry(e);
      end
   endtask

   function automatic logic [EW-1:0] rand_amount();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return UNLIMITED;
         2: return EW'($urandom_range(1, 10));
         3: return EW'($urandom_range(1, 1000));
         default: return EW'($urandom());
      endcase
   endfunction

   // Result side: random stall per beat, compare with the oldest expectation
   int stall_left = 0;
   always @(posedge clock) begin
      psa_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (grant_queue.size() == 0) begin
               report_mismatch("result beat with nothing expected");
            end else begin
               want = grant_queue.pop_front();
               if (rsp_payload.entry_index !== want.entry_index)
                  report_mismatch($sformatf("entry_index %0d, expected %0d",
                     rsp_payload.entry_index, want.entry_index));
               if (rsp_payload.granted_amount !== want.granted_amount)
                  report_mismatch($sformatf("entry %0d granted %0d, expected %0d",
                     want.entry_index, rsp_payload.granted_amount, want.granted_amount));
               if (rsp_payload.last_result !== want.last_result)
                  report_mismatch($sformatf("entry %0d last_result %0b, expected %0b",
                     want.entry_index, rsp_payload.last_result, want.last_result));
            end
            stall_left = idle_on ? $urandom_range(0, 18) : 0;
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Directed sets: extremes and special cases
   task automatic test_directed();
      send_set(UNLIMITED, '{UNLIMITED, 0}, '{UNLIMITED, 5});
      send_set('0, '{3, 7}, '{100, 200});
      send_set(1000, '{1, 2}, '{0, 0});
      send_set(10, '{UNLIMITED, 0, 5}, '{UNLIMITED, UNLIMITED, 3});
      send_set(3, '{0, 0, 0, 9}, '{5, 5, 5, 5});
      send_set(UNLIMITED - 1, '{UNLIMITED, UNLIMITED}, '{UNLIMITED, UNLIMITED});
      send_set(50, '{0}, '{UNLIMITED});
      send_set(UNLIMITED, '{0}, '{0});
      send_set(7, '{1, 3, 0, 2}, '{2, 100, 1, 4});
   endtask

   // More than capacity: entries past the store are dropped
   task automatic test_overflow();
      logic [EW-1:0] used[$], wanted[$];
      for (int k = 0; k < MAXN + 2; k++) begin
         used.push_back(EW'($urandom_range(0, 20)));
         wanted.push_back(EW'($urandom_range(0, 50)));
      end
      send_set(UNLIMITED, used, wanted);
      send_set(400, used, wanted);
   endtask

   // Random sets, mostly small
   task automatic test_random();
      logic [EW-1:0] used[$], wanted[$];
      int n, sent;
      logic [EW-1:0] budget;
      sent = 0;
      while (sent < 180) begin
         idle_on = ($urandom_range(0, 4) != 0);
         n = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 32) : $urandom_range(1, 6);
         used.delete();
         wanted.delete();
         for (int k = 0; k < n; k++) begin
            used.push_back(rand_amount());
            wanted.push_back(rand_amount());
         end
         budget = rand_amount();
         send_set(budget, used, wanted);
         sent += n;
      end
      idle_on = 1'b1;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_overflow();
      test_random();
      req_valid <= 1'b0;
      while (grant_queue.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #200ms;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
